/* rtl/hfd_pkg.sv */
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hfd_pkg;

    // Node index width and the number of indices it can address
    localparam int IDX_W    = 9;
    localparam int IDX_SPAN = 2 ** IDX_W;
    localparam int SYM_W    = 8;

    // Input item kinds carried on s_tuser
    localparam logic OP_WRITE_NODE = 1'b0;
    localparam logic OP_DECODE_BIT = 1'b1;

    // Result status carried on m_tuser
    localparam logic ST_SYMBOL        = 1'b0;
    localparam logic ST_MISSING_CHILD = 1'b1;

    // One node table entry (28 bits)
    typedef struct packed {
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic             left_present;
        logic             right_present;
        logic [SYM_W-1:0] leaf_symbol;
    } node_t;

    // One input item after unpacking
    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] node_slot;
        node_t            node;
        logic             code_bit;
        logic             last_bit;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             status;
    } result_t;

    // Node table access request from the walk control
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        node_t            wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    // Walk control states
    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_FETCH,
        WALK_REFRESH,
        WALK_LOAD
    } walk_state_t;

endpackage

`default_nettype wire

/* rtl/hfd_node_ram.sv */
// Node table memory: one write port, one read port with registered data.
// Depends on hfd_pkg for the entry type and index width.
`default_nettype none

module hfd_node_ram #(
    parameter int NODE_COUNT = 512
) (
    input  wire logic             aclk,
    input  wire hfd_pkg::mem_req_t req,
    output hfd_pkg::node_t        rd_data
);
    import hfd_pkg::*;

    localparam int DEPTH = (NODE_COUNT < IDX_SPAN) ? NODE_COUNT : IDX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(DEPTH);

    node_t mem [DEPTH];
    node_t data_reg;
    logic  oob_reg;

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = {1'b0, req.wr_addr} < DEPTH_W;
    assign rd_in_range = {1'b0, req.rd_addr} < DEPTH_W;

    // Write: drop slots beyond the table
    always_ff @(posedge aclk) begin
        if (req.wr_en && wr_in_range) begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
    end

    // Read: register data and an out-of-range mark
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            oob_reg <= !rd_in_range;
            if (rd_in_range) begin
                data_reg <= mem[req.rd_addr[AW-1:0]];
            end
        end
    end

    // Indices beyond the table read as an all-zero leaf
    assign rd_data = oob_reg ? '0 : data_reg;

endmodule

`default_nettype wire

/* rtl/hfd_out_fifo.sv */
// Two-entry result queue between the walk control and the m_ channel.
// Depends on hfd_pkg for the result type.
`default_nettype none

module hfd_out_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire hfd_pkg::result_t  push_data,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hfd_pkg::result_t       out_data
);
    import hfd_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold result payload
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/hfd_walk.sv */
// Tree-walk control: keeps the current and root nodes, issues table reads
// and writes, and forms results. Depends on hfd_pkg.
`default_nettype none

module hfd_walk #(
    parameter int NODE_COUNT = 512
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [hfd_pkg::IDX_W-1:0]  cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire hfd_pkg::in_item_t          in_item,
    output hfd_pkg::mem_req_t               mem_req,
    input  wire hfd_pkg::node_t             mem_rd_data,
    input  wire logic                       res_full,
    output logic                            res_push,
    output hfd_pkg::result_t                res_data
);
    import hfd_pkg::*;

    localparam int DEPTH = (NODE_COUNT < IDX_SPAN) ? NODE_COUNT : IDX_SPAN;
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(DEPTH);

    walk_state_t      state_reg, state_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic [IDX_W-1:0] walk_pos_reg, walk_pos_next;
    node_t            cur_node_reg, cur_node_next;
    node_t            root_node_reg, root_node_next;
    logic [IDX_W-1:0] fetch_idx_reg, fetch_idx_next;
    logic             fetch_last_reg, fetch_last_next;

    logic             accept;
    logic             is_decode;
    logic             cur_leaf;
    logic             cur_missing;
    logic [IDX_W-1:0] child_idx;
    logic             ne_leaf;
    logic             slot_in_range;

    assign in_ready  = (state_reg == WALK_IDLE) && !res_full;
    assign accept    = in_valid && in_ready;
    assign is_decode = (in_item.operation == OP_DECODE_BIT);

    // Classify the current node against the incoming bit
    assign cur_leaf    = !cur_node_reg.left_present && !cur_node_reg.right_present;
    assign cur_missing = in_item.code_bit ? !cur_node_reg.right_present
                                          : !cur_node_reg.left_present;
    assign child_idx   = in_item.code_bit ? cur_node_reg.right_child
                                          : cur_node_reg.left_child;
    assign ne_leaf     = !mem_rd_data.left_present && !mem_rd_data.right_present;
    assign slot_in_range = {1'b0, in_item.node_slot} < DEPTH_W;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            WALK_IDLE: begin
                if (accept && is_decode && !cur_leaf && !cur_missing) begin
                    state_next = WALK_FETCH;
                end
            end
            WALK_FETCH:   state_next = WALK_IDLE;
            WALK_REFRESH: state_next = WALK_LOAD;
            WALK_LOAD:    state_next = WALK_IDLE;
            default:      state_next = WALK_IDLE;
        endcase
        if (cfg_wr_en) begin
            state_next = WALK_REFRESH;
        end
    end

    // Datapath and outputs
    always_comb begin
        root_next       = root_reg;
        walk_pos_next   = walk_pos_reg;
        cur_node_next   = cur_node_reg;
        root_node_next  = root_node_reg;
        fetch_idx_next  = fetch_idx_reg;
        fetch_last_next = fetch_last_reg;
        mem_req         = '0;
        res_push        = 1'b0;
        res_data        = '0;

        unique case (state_reg)
            WALK_IDLE: begin
                if (accept && !is_decode) begin
                    // Write the node; keep cached copies coherent
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = in_item.node_slot;
                    mem_req.wr_data = in_item.node;
                    if (slot_in_range && in_item.node_slot == walk_pos_reg) begin
                        cur_node_next = in_item.node;
                    end
                    if (slot_in_range && in_item.node_slot == root_reg) begin
                        root_node_next = in_item.node;
                    end
                end else if (accept) begin
                    if (cur_leaf || cur_missing) begin
                        // Emit leaf symbol or missing-child error, back to root
                        res_push        = 1'b1;
                        res_data.status = cur_leaf ? ST_SYMBOL : ST_MISSING_CHILD;
                        res_data.symbol = cur_leaf ? cur_node_reg.leaf_symbol : '0;
                        walk_pos_next   = root_reg;
                        cur_node_next   = root_node_reg;
                    end else begin
                        // Fetch the child node
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = child_idx;
                        fetch_idx_next  = child_idx;
                        fetch_last_next = in_item.last_bit;
                    end
                end
            end
            WALK_FETCH: begin
                if (ne_leaf) begin
                    res_push        = 1'b1;
                    res_data.status = ST_SYMBOL;
                    res_data.symbol = mem_rd_data.leaf_symbol;
                end
                if (ne_leaf || fetch_last_reg) begin
                    walk_pos_next = root_reg;
                    cur_node_next = root_node_reg;
                end else begin
                    walk_pos_next = fetch_idx_reg;
                    cur_node_next = mem_rd_data;
                end
            end
            WALK_REFRESH: begin
                // Read the root entry after a root change
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = root_reg;
            end
            WALK_LOAD: begin
                root_node_next = mem_rd_data;
                cur_node_next  = mem_rd_data;
            end
            default: begin
                walk_pos_next = root_reg;
            end
        endcase

        // Root change restarts the walk
        if (cfg_wr_en) begin
            root_next     = cfg_wr_data;
            walk_pos_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= WALK_IDLE;
            root_reg     <= '0;
            walk_pos_reg <= '0;
        end else begin
            state_reg    <= state_next;
            root_reg     <= root_next;
            walk_pos_reg <= walk_pos_next;
        end
    end

    // Hold cached nodes and fetch context
    always_ff @(posedge aclk) begin
        cur_node_reg   <= cur_node_next;
        root_node_reg  <= root_node_next;
        fetch_idx_reg  <= fetch_idx_next;
        fetch_last_reg <= fetch_last_next;
    end

endmodule

`default_nettype wire

/* rtl/huffman_tree_bit_decoder_core.sv */
// Huffman tree-walk decoder: top level joining walk control, node table
// memory and result queue. Depends on hfd_pkg and the hfd_* modules.
//
// Use:
//   s_ channel carries items: s_tuser selects a node write (0) or a decode
//   bit (1); s_tlast marks the final bit of a stream. Node writes load the
//   table, one node per item, and give no result.
//   m_ channel carries results: m_tdata is the symbol, m_tuser is the
//   status (0 symbol, 1 missing child).
//   cfg_wr_en / cfg_wr_data set the root index and return the walk to it.
// Item handling:
//   A node write needs no further state. A decode bit is resolved in the
//   idle state when the current node is a leaf or lacks the chosen child;
//   otherwise the child is read through the table's single read port and
//   its registered data is used in the fetch state. A result is registered
//   in the result queue before it appears on m_.
// Reset and stall:
//   Reset clears the root and walk position to 0 and empties the queue;
//   table contents are undefined until written. After a root write the
//   block reads the root entry in the refresh and load states before
//   taking items. A two-entry result queue lets input continue while one
//   result waits; s_tready drops when both entries are held.
`default_nettype none

module huffman_tree_bit_decoder_core #(
    parameter int NODE_COUNT = 512
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Configuration
    input  wire logic                       cfg_wr_en,
    input  wire logic [hfd_pkg::IDX_W-1:0]  cfg_wr_data,   // root_node
    // Input items
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [8:0] node_slot, [17:9] left_child, [26:18] right_child,
    // [27] left_present, [28] right_present, [36:29] leaf_symbol,
    // [37] code_bit, [39:38] zero
    input  wire logic [39:0]                s_tdata,
    input  wire logic                       s_tuser,       // [0] operation
    input  wire logic                       s_tlast,       // last_bit
    // Result items
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,       // [7:0] symbol
    output logic                            m_tuser        // [0] status
);
    import hfd_pkg::*;

    in_item_t in_item;
    mem_req_t mem_req;
    node_t    mem_rd_data;
    logic     res_full;
    logic     res_push;
    result_t  res_data;
    result_t  out_data;

    // Unpack the input item
    assign in_item.operation          = s_tuser;
    assign in_item.node_slot          = s_tdata[8:0];
    assign in_item.node.left_child    = s_tdata[17:9];
    assign in_item.node.right_child   = s_tdata[26:18];
    assign in_item.node.left_present  = s_tdata[27];
    assign in_item.node.right_present = s_tdata[28];
    assign in_item.node.leaf_symbol   = s_tdata[36:29];
    assign in_item.code_bit           = s_tdata[37];
    assign in_item.last_bit           = s_tlast;

    hfd_walk #(
        .NODE_COUNT (NODE_COUNT)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (in_item),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    hfd_node_ram #(
        .NODE_COUNT (NODE_COUNT)
    ) u_node_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    hfd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .full      (res_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the result item
    assign m_tdata = out_data.symbol;
    assign m_tuser = out_data.status;

endmodule

`default_nettype wire
